[hdl/pgrepl_pkg.sv]
// Shared types, codes and defaults for the page replacement victim selector.
package pgrepl_pkg;

  localparam int FRAME_COUNT_DEF = 16;
  localparam int STAMP_WIDTH_DEF = 32;

  localparam int FUNC_W  = 2;
  localparam int FRAME_W = 4;
  localparam int ALG_W   = 2;

  typedef enum logic [FUNC_W-1:0] {
    FN_LOAD   = 2'd0,
    FN_ACCESS = 2'd1,
    FN_VICTIM = 2'd2
  } func_t;

  typedef enum logic [ALG_W-1:0] {
    ALG_FIFO  = 2'd0,
    ALG_LRU   = 2'd1,
    ALG_CLOCK = 2'd2
  } alg_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic evt;       // load or access event transfer
    logic fifo_rd;   // read queue head
    logic fifo_fin;  // capture queue head, advance head
    logic lru_init;
    logic lru_run;
    logic clk_init;
    logic clk_run;
    logic out_load;  // move result into output register
  } ctl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic             lru_done;
    logic             clk_done;
    logic             out_free;
    logic [ALG_W-1:0] alg;
  } dp_sts_t;

endpackage

[hdl/pgrepl_dp.sv]
// Datapath: policy state, stamp and queue memories, scan and sweep units, output register.
module pgrepl_dp
  import pgrepl_pkg::*;
#(
  parameter int FRAME_COUNT = FRAME_COUNT_DEF,
  parameter int STAMP_WIDTH = STAMP_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  ctl_cmd_t           cmd,
  output dp_sts_t            sts,
  input  logic [FUNC_W-1:0]  in_func,
  input  logic [FRAME_W-1:0] in_frame,
  input  logic               cfg_we,
  input  logic [ALG_W-1:0]   cfg_alg,
  input  logic               out_ready,
  output logic               out_valid,
  output logic [FRAME_W-1:0] out_frame,
  output logic               out_empty
);

  localparam int IDX_W  = $clog2(FRAME_COUNT);
  localparam int CNT_W  = $clog2(FRAME_COUNT + 1);
  localparam int STEP_W = $clog2(2 * FRAME_COUNT + 1);

  // Configuration
  logic [ALG_W-1:0] alg_r;
  logic             is_fifo, is_lru, is_clock;

  // Frame flags and queue
  logic [FRAME_COUNT-1:0] occ_r, ref_r, filled_r, stamp_vld_r;
  logic [FRAME_W-1:0]     qmem [FRAME_COUNT];
  logic [IDX_W-1:0]       head_r, tail_r;
  logic [FRAME_W-1:0]     q_rdata_r;
  logic                   q_filled_r;

  // LRU stamps
  logic [STAMP_WIDTH-1:0] smem [FRAME_COUNT];
  logic [STAMP_WIDTH-1:0] stamp_cnt_r, stamp_new;
  logic [STAMP_WIDTH-1:0] s_rdata_r, s_val, best_stamp_r;
  logic                   s_rvld_r;
  logic [CNT_W-1:0]       scan_addr_r;
  logic                   rd_vld_r;
  logic [IDX_W-1:0]       rd_idx_r, best_idx_r, new_best;
  logic                   take;
  logic                   lru_done_r;

  // CLOCK sweep
  logic [IDX_W-1:0]  hand_r;
  logic [STEP_W-1:0] step_r;
  logic              clk_done_r;
  logic              hit;

  // Result and output register
  logic [FRAME_W-1:0] res_frame_r, out_frame_r;
  logic               res_empty_r, out_empty_r, out_valid_r;

  // Event decode
  logic             frame_ok, ev_load, ev_access;
  logic [IDX_W-1:0] fidx;

  function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] i);
    next_idx = (i == IDX_W'(FRAME_COUNT - 1)) ? '0 : i + 1'b1;
  endfunction

  assign is_fifo  = (alg_r == ALG_FIFO);
  assign is_lru   = (alg_r == ALG_LRU);
  assign is_clock = !is_fifo && !is_lru;

  assign fidx      = IDX_W'(in_frame);
  assign frame_ok  = (32'(in_frame) < 32'(FRAME_COUNT));
  assign ev_load   = cmd.evt && frame_ok && (in_func == FN_LOAD);
  assign ev_access = cmd.evt && frame_ok && (in_func == FN_ACCESS);

  // Saturating time stamp
  assign stamp_new = (stamp_cnt_r == '1) ? stamp_cnt_r : stamp_cnt_r + 1'b1;

  assign s_val    = s_rvld_r ? s_rdata_r : '0;
  assign take     = (rd_idx_r == '0) || (s_val < best_stamp_r);
  assign new_best = take ? rd_idx_r : best_idx_r;

  assign hit = occ_r[hand_r] && !ref_r[hand_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alg_r       <= ALG_FIFO;
      occ_r       <= '0;
      ref_r       <= '0;
      filled_r    <= '0;
      stamp_vld_r <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      stamp_cnt_r <= '0;
      hand_r      <= '0;
      step_r      <= '0;
      clk_done_r  <= 1'b0;
      lru_done_r  <= 1'b0;
      rd_vld_r    <= 1'b0;
      scan_addr_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        alg_r <= cfg_alg;
      end

      if (ev_load) begin
        occ_r[fidx] <= 1'b1;
        ref_r[fidx] <= 1'b0;
        if (is_fifo) begin
          filled_r[tail_r] <= 1'b1;
          tail_r           <= next_idx(tail_r);
        end
      end
      if ((ev_load || ev_access) && is_lru) begin
        stamp_cnt_r       <= stamp_new;
        stamp_vld_r[fidx] <= 1'b1;
      end
      if (ev_access && is_clock && occ_r[fidx]) begin
        ref_r[fidx] <= 1'b1;
      end

      if (cmd.fifo_fin) begin
        head_r <= next_idx(head_r);
      end

      // LRU scan: one stamp read per cycle, compared in the cycle after the read
      if (cmd.lru_init) begin
        scan_addr_r <= '0;
        rd_vld_r    <= 1'b0;
        lru_done_r  <= 1'b0;
      end else if (cmd.lru_run) begin
        if (scan_addr_r < CNT_W'(FRAME_COUNT)) begin
          rd_vld_r    <= 1'b1;
          scan_addr_r <= scan_addr_r + 1'b1;
        end else begin
          rd_vld_r <= 1'b0;
        end
        if (rd_vld_r && (rd_idx_r == IDX_W'(FRAME_COUNT - 1))) begin
          lru_done_r <= 1'b1;
        end
      end

      // CLOCK sweep: one frame per cycle
      if (cmd.clk_init) begin
        step_r     <= '0;
        clk_done_r <= 1'b0;
      end else if (cmd.clk_run && !clk_done_r) begin
        hand_r <= next_idx(hand_r);
        if (hit || (step_r == STEP_W'(2 * FRAME_COUNT))) begin
          clk_done_r <= 1'b1;
        end else begin
          if (occ_r[hand_r]) begin
            ref_r[hand_r] <= 1'b0;
          end
          step_r <= step_r + 1'b1;
        end
      end

      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers and memories
  always_ff @(posedge clk) begin
    if (ev_load && is_fifo) begin
      qmem[tail_r] <= in_frame;
    end
    if (cmd.fifo_rd) begin
      q_rdata_r  <= qmem[head_r];
      q_filled_r <= filled_r[head_r];
    end

    if ((ev_load || ev_access) && is_lru) begin
      smem[fidx] <= stamp_new;
    end
    if (cmd.lru_run && (scan_addr_r < CNT_W'(FRAME_COUNT))) begin
      s_rdata_r <= smem[scan_addr_r[IDX_W-1:0]];
      s_rvld_r  <= stamp_vld_r[scan_addr_r[IDX_W-1:0]];
      rd_idx_r  <= scan_addr_r[IDX_W-1:0];
    end
    if (cmd.lru_run && rd_vld_r) begin
      best_idx_r <= new_best;
      if (take) begin
        best_stamp_r <= s_val;
      end
    end

    if (cmd.fifo_fin) begin
      res_frame_r <= q_filled_r ? q_rdata_r : '0;
      res_empty_r <= !q_filled_r;
    end else if (cmd.lru_run && rd_vld_r && (rd_idx_r == IDX_W'(FRAME_COUNT - 1))) begin
      res_frame_r <= FRAME_W'(new_best);
      res_empty_r <= 1'b0;
    end else if (cmd.clk_run && !clk_done_r &&
                 (hit || (step_r == STEP_W'(2 * FRAME_COUNT)))) begin
      res_frame_r <= FRAME_W'(hand_r);
      res_empty_r <= 1'b0;
    end

    if (cmd.out_load) begin
      out_frame_r <= res_frame_r;
      out_empty_r <= res_empty_r;
    end
  end

  assign sts.lru_done = lru_done_r;
  assign sts.clk_done = clk_done_r;
  assign sts.out_free = !out_valid_r || out_ready;
  assign sts.alg      = alg_r;

  assign out_valid = out_valid_r;
  assign out_frame = out_frame_r;
  assign out_empty = out_empty_r;

  a_empty_zero : assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load && res_empty_r |-> res_frame_r == '0)
    else $error("empty queue slot result carries a nonzero frame");

  a_step_bound : assert property (@(posedge clk) disable iff (!rst_n)
    step_r <= STEP_W'(2 * FRAME_COUNT))
    else $error("clock sweep ran past two rounds");

  a_clk_hit : assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clk_run && !clk_done_r && hit
    |=> clk_done_r && (res_frame_r == FRAME_W'($past(hand_r))))
    else $error("clock sweep missed an occupied frame with clear reference bit");

endmodule

[hdl/pgrepl_ctrl.sv]
// Controller: sequences event transfers, victim searches and result handoff.
module pgrepl_ctrl
  import pgrepl_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [FUNC_W-1:0] in_func,
  input  dp_sts_t           sts,
  output ctl_cmd_t          cmd
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_FIFO = 5'b00010,
    ST_LRU  = 5'b00100,
    ST_CLK  = 5'b01000,
    ST_DONE = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic   in_xfer, is_victim;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_xfer   = in_valid && in_ready;
  assign is_victim = (in_func == FN_VICTIM);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          if (!is_victim) begin
            cmd.evt = 1'b1;
          end else if (sts.alg == ALG_FIFO) begin
            cmd.fifo_rd = 1'b1;
            state_nxt   = ST_FIFO;
          end else if (sts.alg == ALG_LRU) begin
            cmd.lru_init = 1'b1;
            state_nxt    = ST_LRU;
          end else begin
            cmd.clk_init = 1'b1;
            state_nxt    = ST_CLK;
          end
        end
      end
      ST_FIFO: begin
        cmd.fifo_fin = 1'b1;
        state_nxt    = ST_DONE;
      end
      ST_LRU: begin
        if (sts.lru_done) begin
          state_nxt = ST_DONE;
        end else begin
          cmd.lru_run = 1'b1;
        end
      end
      ST_CLK: begin
        if (sts.clk_done) begin
          state_nxt = ST_DONE;
        end else begin
          cmd.clk_run = 1'b1;
        end
      end
      ST_DONE: begin
        // hold until the output register can take the result
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_load_free : assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> sts.out_free)
    else $error("result loaded over a pending output");

  a_clk_to_done : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLK) && sts.clk_done |=> state_r == ST_DONE)
    else $error("finished clock sweep did not hand off its result");

  a_fifo_start : assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && is_victim && (sts.alg == ALG_FIFO) |=> state_r == ST_FIFO)
    else $error("FIFO victim request did not start a queue read");

endmodule

[hdl/page_replacement_victim_select_top.sv]
// Top level of the page replacement victim selector (FIFO, LRU, CLOCK).
// Load and access events: no result; next item taken the cycle after.
// FIFO victim: queue head read (queue read port), captured as the result, then moved into the output register.
// LRU victim: one stamp memory read per cycle over all frames.
// CLOCK victim: one frame of the sweep per cycle.
// Reset (rst_n low, synchronous) clears mode, pointers, counters and per-frame flags at once.
module page_replacement_victim_select_top
  import pgrepl_pkg::*;
#(
  parameter int FRAME_COUNT = FRAME_COUNT_DEF,
  parameter int STAMP_WIDTH = STAMP_WIDTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [3:0] frame_index, [7:4] zero
  input  logic [1:0] in_tuser,   // [1:0] func
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [3:0] victim_frame, [7:4] zero
  output logic [0:0] out_tuser,  // [0] slot_empty
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_data    // [1:0] algorithm
);

  ctl_cmd_t           cmd;
  dp_sts_t            sts;
  logic [FRAME_W-1:0] out_frame;
  logic               out_empty;

  assign cfg_ready = 1'b1;

  pgrepl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_func  (in_tuser),
    .sts      (sts),
    .cmd      (cmd)
  );

  pgrepl_dp #(
    .FRAME_COUNT (FRAME_COUNT),
    .STAMP_WIDTH (STAMP_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_func   (in_tuser),
    .in_frame  (in_tdata[FRAME_W-1:0]),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_alg   (cfg_data),
    .out_ready (out_tready),
    .out_valid (out_tvalid),
    .out_frame (out_frame),
    .out_empty (out_empty)
  );

  assign out_tdata = {4'b0000, out_frame};
  assign out_tuser = out_empty;

endmodule
